// ===== src/erg_pkg.sv =====
// ----------------------------------------------------------------------------
// erg_pkg
// Shared types and constants of the Euclidean rhythm generator.
// ----------------------------------------------------------------------------
`default_nettype none

package erg_pkg;

   // configuration register file
   localparam int unsigned CSR_W     = 7;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_COUNT  = 1'b1;

   localparam logic [CSR_W-1:0] STEP_COUNT_RESET = 7'd16;
   localparam logic [CSR_W-1:0] HIT_COUNT_RESET  = 7'd4;

   // stream payload widths
   localparam int unsigned ROT_W      = 6;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned MASK_W     = 64;
   localparam int unsigned RSP_USER_W = 1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_GROUP  = 4'b0010,
      ST_LAYOUT = 4'b0100,
      ST_EMIT   = 4'b1000
   } erg_state_type;

endpackage

`default_nettype wire

// ===== src/erg_shift_unit.sv =====
// ----------------------------------------------------------------------------
// erg_shift_unit
// Shared left barrel shifter; a shift by the full width or more gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module erg_shift_unit #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned AMT_W = 7
) (
   input  wire logic [WIDTH-1:0] shift_src,
   input  wire logic [AMT_W-1:0] shift_amt,
   output logic      [WIDTH-1:0] shift_res
);

   always_comb begin
      if (32'(shift_amt) >= WIDTH) begin
         shift_res = '0;
      end else begin
         shift_res = shift_src << shift_amt;
      end
   end

endmodule

`default_nettype wire

// ===== src/euclidean_rhythm_generator.sv =====
// ----------------------------------------------------------------------------
// euclidean_rhythm_generator
// Bjorklund grouping of hits over steps, read out with a per-request rotation.
// ----------------------------------------------------------------------------
// csr_* writes step_count (index 0) and hit_count (index 1); the user must
// write them only while idle, the block does not enforce it. req_* carries
// one rotation per transaction in req_tdata[5:0]; rsp_* returns the rotated
// mask in rsp_tdata and the rotation error in rsp_tuser[0] (mask zero on
// error). req_tready is high only in the idle state. The shared shifter
// runs one grouping round per cycle (at most steps-2 rounds), lays out one
// group per cycle (at most steps groups), then builds the rotated mask in
// the emit state; rounds plus groups never exceed steps. An error, zero
// hits or full hits skip the grouping and layout and go straight to emit.
// The result sits in an output register; a new request is accepted while it
// waits and holds in the emit state until the register frees. Reset is
// synchronous, active high: 16 steps, 4 hits, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module euclidean_rhythm_generator #(
   parameter int unsigned MAX_STEPS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration
   input  wire logic                                csr_wr_en,
   input  wire logic [erg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [erg_pkg::CSR_W-1:0]           csr_wdata,
   // request stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [erg_pkg::REQ_DATA_W-1:0]      req_tdata,   // [5:0] rotation
   // response stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [erg_pkg::MASK_W-1:0]          rsp_tdata,   // [63:0] pattern_mask
   output logic      [erg_pkg::RSP_USER_W-1:0]      rsp_tuser    // [0] rotation_error
);

   localparam int unsigned PW    = MAX_STEPS;
   localparam int unsigned CNT_W = $clog2(MAX_STEPS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STEPS);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   // configuration registers
   logic [erg_pkg::CSR_W-1:0] step_count_ff, step_count_in;
   logic [erg_pkg::CSR_W-1:0] hit_count_ff, hit_count_in;

   // sequencer and datapath
   erg_pkg::erg_state_type state_ff, state_in;
   logic [CNT_W-1:0]         steps_ff, steps_in;
   logic [erg_pkg::ROT_W-1:0] rot_ff, rot_in;
   logic                     err_ff, err_in;
   logic [PW-1:0]            win_ff, win_in;
   logic [PW-1:0]            fbits_ff, fbits_in;
   logic [PW-1:0]            rbits_ff, rbits_in;
   logic [CNT_W-1:0]         flen_ff, flen_in;
   logic [CNT_W-1:0]         rlen_ff, rlen_in;
   logic [CNT_W-1:0]         fcnt_ff, fcnt_in;
   logic [CNT_W-1:0]         rcnt_ff, rcnt_in;
   logic [PW-1:0]            pat_ff, pat_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [erg_pkg::MASK_W-1:0] rsp_data_ff, rsp_data_in;
   logic                      rsp_err_ff, rsp_err_in;

   // shared shifter
   logic [PW-1:0]    shift_src;
   logic [CNT_W-1:0] shift_amt;
   logic [PW-1:0]    shift_res;

   erg_shift_unit #(
      .WIDTH (PW),
      .AMT_W (CNT_W)
   ) u_shift (
      .shift_src (shift_src),
      .shift_amt (shift_amt),
      .shift_res (shift_res)
   );

   // effective step and hit counts
   logic [CNT_W-1:0]          eff_steps;
   logic [CNT_W-1:0]          eff_hits;
   logic [erg_pkg::ROT_W-1:0] req_rot;
   logic                      req_err;
   logic                      req_fire;
   logic                      out_free;
   logic [PW-1:0]             win_ones;
   logic [PW-1:0]             rot_mask;

   assign req_rot  = req_tdata[erg_pkg::ROT_W-1:0];
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign win_ones = ~(PW'(0));

   always_comb begin
      if (step_count_ff > erg_pkg::CSR_W'(MAX_STEPS)) begin
         eff_steps = MAX_CNT;
      end else if (step_count_ff == '0) begin
         eff_steps = ONE_CNT;
      end else begin
         eff_steps = CNT_W'(step_count_ff);
      end
      if (hit_count_ff > erg_pkg::CSR_W'(eff_steps)) begin
         eff_hits = eff_steps;
      end else begin
         eff_hits = CNT_W'(hit_count_ff);
      end
      req_err = (erg_pkg::CSR_W'(req_rot) >= erg_pkg::CSR_W'(eff_steps));
   end

   // shifter source select follows the state
   always_comb begin
      case (state_ff)
         erg_pkg::ST_GROUP: begin
            shift_src = rbits_ff;
            shift_amt = flen_ff;
         end
         erg_pkg::ST_LAYOUT: begin
            shift_src = pat_ff;
            shift_amt = (rcnt_ff != '0) ? rlen_ff : flen_ff;
         end
         erg_pkg::ST_EMIT: begin
            shift_src = pat_ff;
            shift_amt = steps_ff - CNT_W'(rot_ff);
         end
         default: begin
            shift_src = win_ones;
            shift_amt = eff_steps;
         end
      endcase
   end

   assign rot_mask = ((pat_ff >> rot_ff) | shift_res) & win_ff;

   always_comb begin
      state_in     = state_ff;
      steps_in     = steps_ff;
      rot_in       = rot_ff;
      err_in       = err_ff;
      win_in       = win_ff;
      fbits_in     = fbits_ff;
      rbits_in     = rbits_ff;
      flen_in      = flen_ff;
      rlen_in      = rlen_ff;
      fcnt_in      = fcnt_ff;
      rcnt_in      = rcnt_ff;
      pat_in       = pat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      req_tready   = (state_ff == erg_pkg::ST_IDLE);

      case (state_ff)
         erg_pkg::ST_IDLE: begin
            if (req_fire) begin
               steps_in = eff_steps;
               rot_in   = req_rot;
               err_in   = req_err;
               // in idle the shifter gives ones above the window
               win_in   = ~shift_res;
               fbits_in = PW'(1);
               rbits_in = '0;
               flen_in  = ONE_CNT;
               rlen_in  = ONE_CNT;
               fcnt_in  = eff_hits;
               rcnt_in  = eff_steps - eff_hits;
               pat_in   = '0;
               if (req_err || eff_hits == '0) begin
                  state_in = erg_pkg::ST_EMIT;
               end else if (eff_hits == eff_steps) begin
                  pat_in   = ~shift_res;
                  state_in = erg_pkg::ST_EMIT;
               end else begin
                  state_in = erg_pkg::ST_GROUP;
               end
            end
         end
         erg_pkg::ST_GROUP: begin
            if (rcnt_ff > ONE_CNT) begin
               fbits_in = fbits_ff | shift_res;
               flen_in  = flen_ff + rlen_ff;
               fcnt_in  = (fcnt_ff < rcnt_ff) ? fcnt_ff : rcnt_ff;
               if (fcnt_ff > rcnt_ff) begin
                  rbits_in = fbits_ff;
                  rlen_in  = flen_ff;
                  rcnt_in  = fcnt_ff - rcnt_ff;
               end else begin
                  rcnt_in  = rcnt_ff - fcnt_ff;
               end
            end else begin
               state_in = erg_pkg::ST_LAYOUT;
            end
         end
         erg_pkg::ST_LAYOUT: begin
            // built from the last group down so the first group lands at bit 0
            if (rcnt_ff != '0) begin
               pat_in  = shift_res | rbits_ff;
               rcnt_in = rcnt_ff - ONE_CNT;
            end else if (fcnt_ff != '0) begin
               pat_in  = shift_res | fbits_ff;
               fcnt_in = fcnt_ff - ONE_CNT;
            end else begin
               state_in = erg_pkg::ST_EMIT;
            end
         end
         erg_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_data_in  = err_ff ? '0 : erg_pkg::MASK_W'(rot_mask);
               state_in     = erg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = erg_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      step_count_in = step_count_ff;
      hit_count_in  = hit_count_ff;
      if (csr_wr_en) begin
         case (csr_index)
            erg_pkg::CSR_STEP_COUNT: step_count_in = csr_wdata;
            erg_pkg::CSR_HIT_COUNT:  hit_count_in  = csr_wdata;
            default: begin
               step_count_in = step_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= erg_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         step_count_ff <= erg_pkg::STEP_COUNT_RESET;
         hit_count_ff  <= erg_pkg::HIT_COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         step_count_ff <= step_count_in;
         hit_count_ff  <= hit_count_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff    <= steps_in;
      rot_ff      <= rot_in;
      err_ff      <= err_in;
      win_ff      <= win_in;
      fbits_ff    <= fbits_in;
      rbits_ff    <= rbits_in;
      flen_ff     <= flen_in;
      rlen_ff     <= rlen_in;
      fcnt_ff     <= fcnt_in;
      rcnt_ff     <= rcnt_in;
      pat_ff      <= pat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = erg_pkg::RSP_USER_W'(rsp_err_ff);

`ifndef SYNTHESIS
   // an error transaction never carries a mask
   a_err_zero_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_data_ff == '0))
      else $error("rotation error with non-zero mask");

   // grouping keeps the total length equal to the step count
   a_group_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == erg_pkg::ST_GROUP) |->
      ((16'(fcnt_ff) * 16'(flen_ff) + 16'(rcnt_ff) * 16'(rlen_ff)) == 16'(steps_ff)))
      else $error("group lengths do not cover the steps");

   // no more hits than steps in a returned mask
   a_mask_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && state_ff != erg_pkg::ST_EMIT) |->
      ($countones(rsp_data_ff) <= 32'(steps_ff)))
      else $error("mask has more hits than steps");

   // a response is loaded only when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending response overwritten");
`endif

endmodule

`default_nettype wire
